// ----- design/rpes_pkg.sv -----
// Shared types and constants for the resource profile earliest start block.
package rpes_pkg;

  localparam int NUM_RESOURCES_DEF = 4;
  localparam int MAX_HORIZON_DEF   = 1024;
  localparam int CAP_REGS          = 4;
  localparam int TIME_W            = 11;
  localparam int DUR_W             = 8;
  localparam int CAP_W             = 8;
  localparam int RIU_W             = 3;
  localparam int DEM_W             = 32;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 11;

  localparam logic [RIU_W-1:0]  RIU_RESET     = 3'd4;
  localparam logic [TIME_W-1:0] HORIZON_RESET = 11'd1024;

  typedef enum logic [1:0] {
    REQ_QUERY = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RES_IN_USE = 3'd0,
    CFG_HORIZON    = 3'd1,
    CFG_CAP0       = 3'd2,
    CFG_CAP1       = 3'd3,
    CFG_CAP2       = 3'd4,
    CFG_CAP3       = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_ADD,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic rd;
    logic clr;
    logic sub;
  } lane_ctl_t;

endpackage

// ----- design/rpes_lane.sv -----
// One resource lane: capacity memory over the horizon, demand check, saturating update.
module rpes_lane
  import rpes_pkg::*;
#(
  parameter int DEPTH = MAX_HORIZON_DEF,
  parameter int AW    = $clog2(MAX_HORIZON_DEF)
) (
  input  logic             clk,
  input  lane_ctl_t        ctl,
  input  logic             act,
  input  logic [AW-1:0]    rd_addr,
  input  logic [AW-1:0]    wr_addr,
  input  logic [CAP_W-1:0] demand,
  input  logic [CAP_W-1:0] fill,
  output logic             ok
);

  logic [CAP_W-1:0] mem [DEPTH];
  logic [CAP_W-1:0] rd_data_r;
  logic [CAP_W-1:0] sub_val;

  assign ok      = (rd_data_r >= demand);
  assign sub_val = (rd_data_r > demand) ? (rd_data_r - demand) : '0;

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_data_r <= mem[rd_addr];
    end
    if (ctl.clr) begin
      mem[wr_addr] <= fill;
    end else if (ctl.sub && act) begin
      mem[wr_addr] <= sub_val;
    end
  end

endmodule

// ----- design/rpes_ctrl.sv -----
// Sequencer: configuration, request decode, slot walk and merge of lane results.
module rpes_ctrl
  import rpes_pkg::*;
#(
  parameter int NUM_LANES   = NUM_RESOURCES_DEF,
  parameter int MAX_HORIZON = MAX_HORIZON_DEF,
  parameter int AW          = $clog2(MAX_HORIZON_DEF)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_req_type,
  input  logic [TIME_W-1:0]               in_start_time,
  input  logic [DUR_W-1:0]                in_duration,
  input  logic [TIME_W-1:0]               in_stop_time,
  input  logic [DEM_W-1:0]                in_demands,
  output logic                            out_valid,
  output logic [TIME_W-1:0]               out_result_time,
  output logic                            out_fits,
  input  logic                            cfg_we,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_wdata,
  output lane_ctl_t                       lane_ctl,
  output logic [AW-1:0]                   rd_addr,
  output logic [AW-1:0]                   wr_addr,
  output logic [NUM_LANES-1:0]            lane_act,
  output logic [NUM_LANES-1:0][CAP_W-1:0] lane_dem,
  output logic [NUM_LANES-1:0][CAP_W-1:0] lane_fill,
  input  logic [NUM_LANES-1:0]            lane_ok
);

  localparam int TW = $clog2(MAX_HORIZON + 1);
  localparam int CW = (TW > TIME_W) ? TW : TIME_W;
  localparam logic [CW-1:0] MAXH      = CW'(MAX_HORIZON);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_HORIZON - 1);

  state_t                  state_r, state_nxt;
  logic                    init_r, init_nxt;
  logic [RIU_W-1:0]        riu_r;
  logic [TIME_W-1:0]       hor_r;
  logic [CAP_REGS-1:0][CAP_W-1:0] cap_r;
  logic [CW-1:0]           rd_r, rd_nxt;
  logic                    pv_r, pv_nxt;
  logic                    ov_r, ov_nxt;
  logic [CW-1:0]           t_r, t_nxt;
  logic [CW-1:0]           lim_r, lim_nxt;
  logic [AW-1:0]           wa_r, wa_nxt;
  logic [DUR_W-1:0]        run_r, run_nxt;
  logic [DUR_W-1:0]        dur_r, dur_nxt;
  logic [DEM_W-1:0]        dem_r, dem_nxt;
  logic [TIME_W-1:0]       ores_r, ores_nxt;
  logic                    ofits_r, ofits_nxt;

  logic [CW-1:0]    hz;
  logic [CW-1:0]    stop_c;
  logic             accept;
  logic             ok_all;
  logic             issue;
  logic [DUR_W-1:0] run_e;
  logic [CW-1:0]    t_e;
  logic             q_done;
  logic             add_done;
  logic             clr_done;

  assign hz       = (CW'(hor_r) < MAXH) ? CW'(hor_r) : MAXH;
  assign stop_c   = (CW'(in_stop_time) < hz) ? CW'(in_stop_time) : hz;
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign ok_all   = &(lane_ok | ~lane_act);
  assign issue    = (rd_r < lim_r);
  assign run_e    = pv_r ? (ok_all ? run_r + 1'b1 : '0) : run_r;
  assign t_e      = pv_r ? t_r + 1'b1 : t_r;
  assign q_done   = (run_e >= dur_r) || (t_e >= lim_r);
  assign add_done = !issue && !pv_r;
  assign clr_done = (rd_r[AW-1:0] == LAST_ADDR);

  assign rd_addr  = rd_r[AW-1:0];
  assign wr_addr  = (state_r == ST_CLEAR) ? rd_r[AW-1:0] : wa_r;

  assign out_valid       = ov_r;
  assign out_result_time = ores_r;
  assign out_fits        = ofits_r;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_act[i]  = (RIU_W'(i) < riu_r);
      lane_dem[i]  = dem_r[i*CAP_W +: CAP_W];
      lane_fill[i] = init_r ? '0 : cap_r[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req_t'(in_req_type))
            REQ_QUERY: state_nxt = ST_QUERY;
            REQ_ADD:   state_nxt = ST_ADD;
            REQ_CLEAR: state_nxt = ST_CLEAR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_QUERY: begin
        if (q_done) state_nxt = ST_IDLE;
      end
      ST_ADD: begin
        if (add_done) state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        if (clr_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    init_nxt  = init_r;
    rd_nxt    = rd_r;
    pv_nxt    = 1'b0;
    ov_nxt    = 1'b0;
    t_nxt     = t_r;
    lim_nxt   = lim_r;
    wa_nxt    = wa_r;
    run_nxt   = run_r;
    dur_nxt   = dur_r;
    dem_nxt   = dem_r;
    ores_nxt  = ores_r;
    ofits_nxt = ofits_r;
    lane_ctl  = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          dem_nxt = in_demands;
          dur_nxt = in_duration;
          run_nxt = '0;
          t_nxt   = CW'(in_start_time);
          rd_nxt  = CW'(in_start_time);
          case (req_t'(in_req_type))
            REQ_QUERY: lim_nxt = hz;
            REQ_ADD:   lim_nxt = stop_c;
            REQ_CLEAR: rd_nxt  = '0;
            default: begin
              ov_nxt    = 1'b1;
              ores_nxt  = '0;
              ofits_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_QUERY: begin
        lane_ctl.rd = issue;
        if (issue) rd_nxt = rd_r + 1'b1;
        pv_nxt  = issue;
        run_nxt = run_e;
        t_nxt   = t_e;
        if (q_done) begin
          ov_nxt    = 1'b1;
          ores_nxt  = TIME_W'(t_e - CW'(run_e));
          ofits_nxt = (run_e >= dur_r);
        end
      end
      ST_ADD: begin
        lane_ctl.rd  = issue;
        lane_ctl.sub = pv_r;
        if (issue) rd_nxt = rd_r + 1'b1;
        pv_nxt = issue;
        wa_nxt = rd_r[AW-1:0];
        if (add_done) begin
          ov_nxt    = 1'b1;
          ores_nxt  = '0;
          ofits_nxt = 1'b0;
        end
      end
      ST_CLEAR: begin
        lane_ctl.clr = 1'b1;
        rd_nxt       = rd_r + 1'b1;
        if (clr_done) begin
          init_nxt = 1'b0;
          if (!init_r) begin
            ov_nxt    = 1'b1;
            ores_nxt  = '0;
            ofits_nxt = 1'b0;
          end
        end
      end
      default: begin
        lane_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      init_r  <= 1'b1;
      rd_r    <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
      riu_r   <= RIU_RESET;
      hor_r   <= HORIZON_RESET;
      cap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      rd_r    <= rd_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RES_IN_USE: riu_r    <= cfg_wdata[RIU_W-1:0];
          CFG_HORIZON:    hor_r    <= cfg_wdata[TIME_W-1:0];
          CFG_CAP0:       cap_r[0] <= cfg_wdata[CAP_W-1:0];
          CFG_CAP1:       cap_r[1] <= cfg_wdata[CAP_W-1:0];
          CFG_CAP2:       cap_r[2] <= cfg_wdata[CAP_W-1:0];
          CFG_CAP3:       cap_r[3] <= cfg_wdata[CAP_W-1:0];
          default:        riu_r    <= riu_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    lim_r   <= lim_nxt;
    wa_r    <= wa_nxt;
    run_r   <= run_nxt;
    dur_r   <= dur_nxt;
    dem_r   <= dem_nxt;
    ores_r  <= ores_nxt;
    ofits_r <= ofits_nxt;
  end

endmodule

// ----- design/resource_profile_earliest_start.sv -----
// Top level: time-indexed resource capacity profile with earliest start search.
// Query: scans slots from the start time, one slot per cycle.
// Add: one read-modify-write per cycle.
// Clear: one slot of every lane per cycle; one item at a time.
// Reset: synchronous; a clearing pass to zero over every slot follows, busy high.
// One result strobe per item; the receiver cannot stall.
module resource_profile_earliest_start
  import rpes_pkg::*;
#(
  parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
  parameter int MAX_HORIZON   = MAX_HORIZON_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_req_type,
  input  logic [TIME_W-1:0]     in_start_time,
  input  logic [DUR_W-1:0]      in_duration,
  input  logic [TIME_W-1:0]     in_stop_time,
  input  logic [DEM_W-1:0]      in_demands,
  output logic                  out_valid,
  output logic [TIME_W-1:0]     out_result_time,
  output logic                  out_fits,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NL = (NUM_RESOURCES < CAP_REGS) ? NUM_RESOURCES : CAP_REGS;
  localparam int AW = $clog2(MAX_HORIZON);

  lane_ctl_t                lane_ctl;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic [NL-1:0]            lane_act;
  logic [NL-1:0][CAP_W-1:0] lane_dem;
  logic [NL-1:0][CAP_W-1:0] lane_fill;
  logic [NL-1:0]            lane_ok;

  rpes_ctrl #(
    .NUM_LANES   (NL),
    .MAX_HORIZON (MAX_HORIZON),
    .AW          (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_start_time   (in_start_time),
    .in_duration     (in_duration),
    .in_stop_time    (in_stop_time),
    .in_demands      (in_demands),
    .out_valid       (out_valid),
    .out_result_time (out_result_time),
    .out_fits        (out_fits),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .lane_ctl        (lane_ctl),
    .rd_addr         (rd_addr),
    .wr_addr         (wr_addr),
    .lane_act        (lane_act),
    .lane_dem        (lane_dem),
    .lane_fill       (lane_fill),
    .lane_ok         (lane_ok)
  );

  for (genvar g = 0; g < NL; g++) begin : g_lane
    rpes_lane #(
      .DEPTH (MAX_HORIZON),
      .AW    (AW)
    ) u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .act     (lane_act[g]),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .demand  (lane_dem[g]),
      .fill    (lane_fill[g]),
      .ok      (lane_ok[g])
    );
  end

endmodule

// ----- design/rpes_checker.sv -----
// Port-level checks for the resource profile block, bound to the top level.
module rpes_props
  import rpes_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [1:0]        in_req_type,
  input logic              out_valid,
  input logic [TIME_W-1:0] out_result_time,
  input logic              out_fits
);

  localparam logic [1:0] REQ_RSVD = 2'd3;

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result strobe without a pending item");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_unused_code: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == REQ_RSVD) |=>
      (out_valid && !out_fits && out_result_time == '0))
    else $error("unused request code did not give an empty result");

  a_work_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type != REQ_RSVD) |=> (busy && !out_valid))
    else $error("accepted request did not raise busy");

endmodule

bind resource_profile_earliest_start rpes_props u_rpes_props (.*);
